// ===== sv/mipc_pkg.sv =====
// mip chain region generator: shared types, format codes and the level size function
// no dependencies; every other file of the block imports this package
`default_nettype none

package mipc_pkg;

  localparam int unsigned DIM_W      = 15;
  localparam int unsigned LVL_W      = 4;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned FMT_W      = 3;
  localparam int unsigned REQ_W      = 8;
  localparam int unsigned RESULT_CAP = 15;

  localparam logic [FMT_W-1:0] FMT_BC1   = 3'd0;
  localparam logic [FMT_W-1:0] FMT_BC23  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA8 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_R8    = 3'd3;

  // state of one level as it travels down the chain
  typedef struct packed {
    logic [LVL_W-1:0]   lv;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [BYTES_W-1:0] offset;
    logic [BYTES_W-1:0] sz;
    logic [FMT_W-1:0]   fmt;
    logic [BYTES_W-1:0] avail;
    logic [LVL_W-1:0]   levels;
  } tok_t;

  typedef struct packed {
    logic [LVL_W-1:0]   level_index;
    logic [BYTES_W-1:0] byte_offset;
    logic [DIM_W-1:0]   level_width;
    logic [DIM_W-1:0]   level_height;
    logic [BYTES_W-1:0] level_bytes;
  } region_t;

  // what the active cell reports in a cycle
  typedef struct packed {
    logic    valid;
    logic    ok;
    logic    final_lv;
    region_t region;
  } evt_t;

  // bytes of one level: 4x4 blocks rounded up for block formats, per pixel for RGBA8 and R8, else zero
  function automatic logic [BYTES_W-1:0] level_size(logic [FMT_W-1:0] fmt,
                                                    logic [DIM_W-1:0] w,
                                                    logic [DIM_W-1:0] h);
    logic [DIM_W-2:0]   bw;
    logic [DIM_W-2:0]   bh;
    logic [DIM_W-1:0]   a;
    logic [DIM_W-1:0]   b;
    logic [2*DIM_W-1:0] p;
    logic [BYTES_W-1:0] r;
    bw = 14'(({1'b0, w} + 16'd3) >> 2);
    bh = 14'(({1'b0, h} + 16'd3) >> 2);
    if (fmt == FMT_BC1 || fmt == FMT_BC23) begin
      a = {1'b0, bw};
      b = {1'b0, bh};
    end else begin
      a = w;
      b = h;
    end
    p = 30'(a) * 30'(b);
    case (fmt)
      FMT_BC1:   r = {p[28:0], 3'b000};
      FMT_BC23:  r = {p[27:0], 4'b0000};
      FMT_RGBA8: r = {p, 2'b00};
      FMT_R8:    r = {2'b00, p};
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mipc_cell.sv =====
// mip chain region generator: one cell of the level chain
// checks its level against the data size and sizes the next level; uses mipc_pkg
`default_nettype none

module mipc_cell
  import mipc_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  shift,
  input  wire  in_valid,
  input  tok_t in_tok,
  output logic out_valid,
  output tok_t out_tok,
  output evt_t evt
);

  logic tok_valid;
  tok_t tok;

  logic [BYTES_W:0]   sum;
  logic               ok;
  logic               final_lv;
  logic [DIM_W-1:0]   w_half;
  logic [DIM_W-1:0]   h_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (shift) begin
      tok_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      tok <= in_tok;
    end
  end

  always_comb begin
    sum      = {1'b0, tok.offset} + {1'b0, tok.sz};
    ok       = (tok.sz != '0) && (sum <= {1'b0, tok.avail});
    final_lv = (({1'b0, tok.lv} + 5'd1) == {1'b0, tok.levels});
    // halve, never below one pixel
    w_half   = (tok.w >> 1) == '0 ? DIM_W'(1) : (tok.w >> 1);
    h_half   = (tok.h >> 1) == '0 ? DIM_W'(1) : (tok.h >> 1);

    out_valid      = tok_valid && ok && !final_lv;
    out_tok.lv     = tok.lv + LVL_W'(1);
    out_tok.w      = w_half;
    out_tok.h      = h_half;
    out_tok.offset = sum[BYTES_W-1:0];
    out_tok.sz     = level_size(tok.fmt, w_half, h_half);
    out_tok.fmt    = tok.fmt;
    out_tok.avail  = tok.avail;
    out_tok.levels = tok.levels;

    evt = '0;
    if (tok_valid) begin
      evt.valid               = 1'b1;
      evt.ok                  = ok;
      evt.final_lv            = final_lv;
      evt.region.level_index  = tok.lv;
      evt.region.byte_offset  = tok.offset;
      evt.region.level_width  = tok.w;
      evt.region.level_height = tok.h;
      evt.region.level_bytes  = tok.sz;
    end
  end

endmodule

`default_nettype wire

// ===== sv/mipc_collect.sv =====
// mip chain region generator: result collector and output register
// holds one region back until the next level decides its last flag; uses mipc_pkg
`default_nettype none

module mipc_collect
  import mipc_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  evt_t    evt,
  input  wire     m_tready,
  output logic    adv,
  output logic    hold_busy,
  output logic    m_tvalid,
  output region_t m_region,
  output logic    m_last,
  output logic    m_err
);

  logic    hv;
  logic    hfinal;
  region_t hreg;

  logic    hv_next;
  logic    hfinal_next;
  region_t hreg_next;
  logic    push;
  region_t push_region;
  logic    push_last;
  logic    push_err;

  assign adv       = !m_tvalid || m_tready;
  assign hold_busy = hv;

  always_comb begin
    hv_next     = hv;
    hfinal_next = hfinal;
    hreg_next   = hreg;
    push        = 1'b0;
    push_region = hreg;
    push_last   = 1'b0;
    push_err    = 1'b0;
    if (hv && hfinal) begin
      // held region was the last level asked for
      push      = 1'b1;
      push_last = 1'b1;
      hv_next   = 1'b0;
    end else if (evt.valid) begin
      if (evt.ok) begin
        push        = hv;
        hv_next     = 1'b1;
        hfinal_next = evt.final_lv;
        hreg_next   = evt.region;
      end else if (hv) begin
        // level overruns: held region closes the run
        push      = 1'b1;
        push_last = 1'b1;
        hv_next   = 1'b0;
      end else begin
        // not even level zero fits
        push        = 1'b1;
        push_region = '0;
        push_err    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      hv       <= hv_next;
      m_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hfinal <= hfinal_next;
      hreg   <= hreg_next;
      if (push) begin
        m_region <= push_region;
        m_last   <= push_last;
        m_err    <= push_err;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/mip_chain_upload_region_generator_top.sv =====
// mip chain region generator: top level with request front end and chain of level cells
// depends on mipc_pkg, mipc_cell and mipc_collect
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   one upload request item
// m_*      out  m_tvalid/m_tready   one region item, or one error item
//
// one request at a time: the accepted item loads cell zero, then a token walks the
// chain one cell (one mip level) per cycle unless m_tready stalls; a region is held
// in the collector while the next level decides its last flag, then moves on to the
// output register behind m_tdata; an error item goes straight to the output register
// a request yields at most 15 regions
// reset clears the token valids, the held region and the output valid
// a stall on m_tready freezes the whole chain; s_tready stays low while a token
// or a held region is in flight, but not while only the output register is full
`default_nettype none

module mip_chain_upload_region_generator_top
  import mipc_pkg::*;
#(
  parameter int unsigned MAX_DIM_LOG2 = 14
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // width[14:0], height[29:15], requested_levels[37:30], data_size[69:38], zero pad
  input  wire  [71:0]  s_tdata,
  // format_class[2:0]
  input  wire  [2:0]   s_tuser,
  output logic         m_tvalid,
  input  wire          m_tready,
  // level_index[3:0], byte_offset[35:4], level_width[50:36], level_height[65:51],
  // level_bytes[97:66], zero pad
  output logic [103:0] m_tdata,
  // no_usable_level[0]
  output logic [0:0]   m_tuser,
  // last_region
  output logic         m_tlast
);

  // one cell per admissible level
  localparam int unsigned NUM_CELLS =
    (MAX_DIM_LOG2 + 1 < RESULT_CAP) ? MAX_DIM_LOG2 + 1 : RESULT_CAP;

  // request fields
  logic [DIM_W-1:0]   in_w;
  logic [DIM_W-1:0]   in_h;
  logic [REQ_W-1:0]   in_req;
  logic [BYTES_W-1:0] in_avail;
  logic [FMT_W-1:0]   in_fmt;

  assign in_w     = s_tdata[14:0];
  assign in_h     = s_tdata[29:15];
  assign in_req   = s_tdata[37:30];
  assign in_avail = s_tdata[69:38];
  assign in_fmt   = s_tuser[2:0];

  logic               s_acc;
  logic               adv;
  logic               hold_busy;
  logic [DIM_W-1:0]   max_dim;
  logic [LVL_W-1:0]   lim;
  logic [REQ_W-1:0]   req_c;
  logic [LVL_W-1:0]   lvls_a;
  logic [LVL_W-1:0]   lvls;
  tok_t               front;

  // chain links: link k feeds cell k
  logic               link_valid [NUM_CELLS+1];
  tok_t               link_tok   [NUM_CELLS+1];
  evt_t               cell_evt   [NUM_CELLS];
  evt_t               evt_any;
  region_t            m_region;
  logic               m_last;
  logic               m_err;

  assign s_acc = s_tvalid && s_tready;

  // level count: request clamped to 1 .. floor(log2(max(w,h)))+1 and the cell count
  always_comb begin
    max_dim = (in_w > in_h) ? in_w : in_h;
    lim     = LVL_W'(1);
    for (int i = 0; i < DIM_W; i++) begin
      if (max_dim[i]) begin
        lim = LVL_W'(i + 1);
      end
    end
    req_c  = (in_req == '0) ? REQ_W'(1) : in_req;
    lvls_a = (req_c > {4'b0000, lim}) ? lim : req_c[LVL_W-1:0];
    lvls   = ({1'b0, lvls_a} > 5'(NUM_CELLS)) ? LVL_W'(NUM_CELLS) : lvls_a;
  end

  // token for level zero; a lone level takes the whole blob
  always_comb begin
    front.lv     = '0;
    front.w      = in_w;
    front.h      = in_h;
    front.offset = '0;
    front.sz     = (lvls == LVL_W'(1)) ? in_avail : level_size(in_fmt, in_w, in_h);
    front.fmt    = in_fmt;
    front.avail  = in_avail;
    front.levels = lvls;
  end

  assign link_valid[0] = s_acc;
  assign link_tok[0]   = front;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic shift;
    // cell zero also loads while the output side stalls, the chain is empty then
    assign shift = (k == 0) ? (adv || s_acc) : adv;

    mipc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .in_valid  (link_valid[k]),
      .in_tok    (link_tok[k]),
      .out_valid (link_valid[k+1]),
      .out_tok   (link_tok[k+1]),
      .evt       (cell_evt[k])
    );
  end

  // at most one cell holds the token, the others report zero
  always_comb begin
    evt_any = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      evt_any = evt_t'(evt_any | cell_evt[k]);
    end
  end

  mipc_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt_any),
    .m_tready  (m_tready),
    .adv       (adv),
    .hold_busy (hold_busy),
    .m_tvalid  (m_tvalid),
    .m_region  (m_region),
    .m_last    (m_last),
    .m_err     (m_err)
  );

  assign s_tready = !evt_any.valid && !hold_busy;

  assign m_tdata = {6'b000000, m_region.level_bytes, m_region.level_height,
                    m_region.level_width, m_region.byte_offset, m_region.level_index};
  assign m_tuser = m_err;
  assign m_tlast = m_last;

endmodule

`default_nettype wire

// ===== test/mip_chain_upload_region_generator_top_tb.sv =====
// testbench for mip_chain_upload_region_generator_top: directed requests, then random ones
// depends on mipc_pkg and the block's rtl; regions are checked against a predictor built in

module mip_chain_upload_region_generator_top_tb
  import mipc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 85;
  localparam int DRAIN_CYCLES = 40;
  // worst case is ~110 requests x 15 regions x the longest receiver hold, far below this
  localparam int CYCLE_LIMIT  = 300000;

  localparam int unsigned MAX_DIM_LOG2 = 14;
  // the chain length is bounded by the dimension cap and by the result cap
  localparam int unsigned CHAIN_CAP =
    (MAX_DIM_LOG2 + 1 < RESULT_CAP) ? MAX_DIM_LOG2 + 1 : RESULT_CAP;

  // format classes the package leaves unnamed: all of them size to zero
  localparam logic [FMT_W-1:0] FMT_UNKNOWN     = 3'd4;
  localparam logic [FMT_W-1:0] FMT_UNKNOWN_TOP = 3'd7;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [FMT_W-1:0]   fmt;
    logic [REQ_W-1:0]   levels;
    logic [BYTES_W-1:0] data_size;
  } upload_req_t;

  typedef struct packed {
    region_t region;
    logic    last_region;
    logic    no_usable_level;
  } region_item_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    ROW_PREDICT,  // through the predictor
    ROW_ERROR,    // one no-usable-level item, all else zero
    ROW_SINGLE    // one level of the request's extent, sized to data_size
  } row_kind_e;

  typedef struct packed {
    upload_req_t req;
    row_kind_e   kind;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB, RX_HOLD} rx_mode_e;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // zero extent with one level: data_size verbatim
    '{'{15'd0,     15'd0,     FMT_BC1,         8'd1,   32'd100},         ROW_SINGLE},
    // single level with nothing to copy
    '{'{15'd0,     15'd0,     FMT_R8,          8'd0,   32'd0},           ROW_ERROR},
    '{'{15'd1,     15'd1,     FMT_RGBA8,       8'd255, 32'hFFFF_FFFF},   ROW_SINGLE},
    // chains at the dimension extremes, full where the blob holds them
    '{'{15'd16384, 15'd16384, FMT_BC1,         8'd255, 32'hFFFF_FFFF},   ROW_PREDICT},
    '{'{15'h7FFF,  15'h7FFF,  FMT_RGBA8,       8'd255, 32'hFFFF_FFFF},   ROW_PREDICT},
    '{'{15'h7FFF,  15'd1,     FMT_R8,          8'd15,  32'hFFFF_FFFF},   ROW_PREDICT},
    '{'{15'd1,     15'h7FFF,  FMT_BC23,        8'd8,   32'h0100_0000},   ROW_PREDICT},
    // unknown format: nothing with several levels, data_size with one
    '{'{15'd64,    15'd64,    FMT_UNKNOWN,     8'd7,   32'd100000},      ROW_ERROR},
    '{'{15'd64,    15'd64,    FMT_UNKNOWN_TOP, 8'd1,   32'd555},         ROW_SINGLE},
    // zero requested levels count as one
    '{'{15'd8,     15'd8,     FMT_UNKNOWN,     8'd0,   32'h8000_0001},   ROW_SINGLE},
    // zero extent on one side kills level 0
    '{'{15'd0,     15'd64,    FMT_BC1,         8'd7,   32'd1000},        ROW_ERROR},
    '{'{15'd64,    15'd0,     FMT_RGBA8,       8'd7,   32'd1000},        ROW_ERROR},
    // level 0 overruns, then fits exactly
    '{'{15'd64,    15'd64,    FMT_BC1,         8'd7,   32'd10},          ROW_ERROR},
    '{'{15'd64,    15'd64,    FMT_BC1,         8'd7,   32'd2048},        ROW_PREDICT},
    '{'{15'd64,    15'd64,    FMT_BC23,        8'd7,   32'h0001_0000},   ROW_PREDICT},
    '{'{15'd100,   15'd37,    FMT_RGBA8,       8'd3,   32'h0010_0000},   ROW_PREDICT},
    // block rounding on odd sizes, then a one-pixel-high strip
    '{'{15'd5,     15'd3,     FMT_BC1,         8'd2,   32'd1000},        ROW_PREDICT},
    '{'{15'd1024,  15'd1,     FMT_R8,          8'd11,  32'd4096},        ROW_PREDICT},
    // request above the admissible count
    '{'{15'd256,   15'd256,   FMT_R8,          8'd20,  32'h0010_0000},   ROW_PREDICT},
    '{'{15'd1,     15'd1,     FMT_BC23,        8'd0,   32'd0},           ROW_ERROR},
    // exact fit of the chain, then one byte short
    '{'{15'd2,     15'd2,     FMT_BC1,         8'd2,   32'd16},          ROW_PREDICT},
    '{'{15'd2,     15'd2,     FMT_BC1,         8'd2,   32'd15},          ROW_PREDICT},
    '{'{15'd16383, 15'd16383, FMT_BC23,        8'd15,  32'hFFFF_FFFF},   ROW_PREDICT},
    '{'{15'd12345, 15'd6789,  FMT_UNKNOWN_TOP, 8'd1,   32'hDEAD_BEEF},   ROW_SINGLE},
    '{'{15'd3,     15'd3,     FMT_R8,          8'd2,   32'h7FFF_FFFF},   ROW_PREDICT}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [71:0]  s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         m_tlast;

  // regions still owed by the block, oldest first
  region_item_t pending_regions[$];
  // scratch for one predicted chain
  region_item_t chain_plan [CHAIN_CAP];

  int mismatch_count = 0;
  int request_count  = 0;
  int region_count   = 0;
  int no_level_count = 0;
  int burst_left     = 0;
  int cycle_count    = 0;

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_tick = 0;
  int       stall_left = 0;

  region_item_t seen_item;
  region_item_t owed_item;

  mip_chain_upload_region_generator_top #(
    .MAX_DIM_LOG2(MAX_DIM_LOG2)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // bytes of one level: 4x4 blocks rounded up for the block formats, per pixel for RGBA8 and R8, else zero
  function automatic longint unsigned level_footprint(logic [FMT_W-1:0] fmt,
                                                      int unsigned w, int unsigned h);
    longint unsigned bw;
    longint unsigned bh;
    bw = (longint'(w) + 3) / 4;
    bh = (longint'(h) + 3) / 4;
    case (fmt)
      FMT_BC1:   return bw * bh * 8;
      FMT_BC23:  return bw * bh * 16;
      FMT_RGBA8: return longint'(w) * longint'(h) * 4;
      FMT_R8:    return longint'(w) * longint'(h);
      default:   return 0;
    endcase
  endfunction

  // lays out the regions of one request into chain_plan and returns how many
  function automatic int predict_regions(upload_req_t rq);
    int unsigned     w;
    int unsigned     h;
    int unsigned     span;
    int unsigned     limit;
    int unsigned     levels;
    longint unsigned offset;
    longint unsigned sz;
    int              n;
    w = rq.width;
    h = rq.height;
    levels = (rq.levels == 0) ? 1 : rq.levels;
    // admissible count: floor(log2(max(w,h))) + 1
    span = (w > h) ? w : h;
    limit = 1;
    while (span > 1) begin
      span = span / 2;
      limit++;
    end
    if (levels > limit) levels = limit;
    if (levels > CHAIN_CAP) levels = CHAIN_CAP;
    offset = 0;
    n = 0;
    for (int unsigned lv = 0; lv < levels; lv++) begin
      sz = (levels == 1) ? longint'(rq.data_size) : level_footprint(rq.fmt, w, h);
      // stop at the first empty level or the first one past the blob
      if (sz == 0 || offset + sz > rq.data_size) break;
      chain_plan[n] = '0;
      chain_plan[n].region.level_index  = lv[LVL_W-1:0];
      chain_plan[n].region.byte_offset  = offset[BYTES_W-1:0];
      chain_plan[n].region.level_width  = w[DIM_W-1:0];
      chain_plan[n].region.level_height = h[DIM_W-1:0];
      chain_plan[n].region.level_bytes  = sz[BYTES_W-1:0];
      n++;
      offset += sz;
      w = (w / 2 < 1) ? 1 : w / 2;
      h = (h / 2 < 1) ? 1 : h / 2;
    end
    if (n == 0) begin
      chain_plan[0] = '0;
      chain_plan[0].no_usable_level = 1'b1;
      return 1;
    end
    chain_plan[n-1].last_region = 1'b1;
    return n;
  endfunction

  // appends one owed region at the young end of the queue
  function automatic void owe_item(region_item_t it);
    pending_regions.insert(pending_regions.size(), it);
  endfunction

  function automatic void queue_prediction(upload_req_t rq);
    int n;
    n = predict_regions(rq);
    for (int i = 0; i < n; i++) owe_item(chain_plan[i]);
  endfunction

  // random extent: mostly small, some powers of two, some anywhere in 15 bits
  function automatic logic [DIM_W-1:0] rand_extent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DIM_W'($urandom_range(1, 70));
      4:          return DIM_W'($urandom_range(0, 3));
      5, 6:       return DIM_W'(1 << $urandom_range(0, MAX_DIM_LOG2));
      7:          return DIM_W'($urandom_range(1, 16384));
      default:    return DIM_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  task automatic check_region(region_item_t want, region_item_t got);
    if (got.region.level_index != want.region.level_index)
      report_mismatch("level_index", want.region.level_index, got.region.level_index);
    if (got.region.byte_offset != want.region.byte_offset)
      report_mismatch("byte_offset", want.region.byte_offset, got.region.byte_offset);
    if (got.region.level_width != want.region.level_width)
      report_mismatch("level_width", want.region.level_width, got.region.level_width);
    if (got.region.level_height != want.region.level_height)
      report_mismatch("level_height", want.region.level_height, got.region.level_height);
    if (got.region.level_bytes != want.region.level_bytes)
      report_mismatch("level_bytes", want.region.level_bytes, got.region.level_bytes);
    if (got.last_region != want.last_region)
      report_mismatch("last_region", want.last_region, got.last_region);
    if (got.no_usable_level != want.no_usable_level)
      report_mismatch("no_usable_level", want.no_usable_level, got.no_usable_level);
  endtask

  // sender side: bursts of random length, random gaps in between, some back to back
  task automatic send_request(upload_req_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, rq.data_size, rq.levels, rq.height, rq.width};
    s_tuser  <= rq.fmt;
    // s_tready read here is the value the edge just sampled
    do @(posedge clk); while (!s_tready);
    request_count++;
  endtask

  // receiver side: switches between randomly chosen modes: always ready, coin flips,
  // a fixed comb and long random holds
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 50 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: m_tready <= 1'b1;
      RX_COIN: m_tready <= ($urandom_range(0, 3) != 0);
      RX_COMB: m_tready <= (rx_tick % 4 != 3);
      default: begin
        if (stall_left != 0) begin
          m_tready   <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  // result checker: every accepted item is held against the oldest owed region
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_item.region.level_index  = m_tdata[3:0];
      seen_item.region.byte_offset  = m_tdata[35:4];
      seen_item.region.level_width  = m_tdata[50:36];
      seen_item.region.level_height = m_tdata[65:51];
      seen_item.region.level_bytes  = m_tdata[97:66];
      seen_item.last_region         = m_tlast;
      seen_item.no_usable_level     = m_tuser[0];
      if (pending_regions.size() == 0) begin
        report_mismatch("item with nothing owed, level_index", 0,
                        seen_item.region.level_index);
      end else begin
        owed_item = pending_regions.pop_front();
        check_region(owed_item, seen_item);
      end
      if (seen_item.no_usable_level) no_level_count++;
      else region_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still owed", cycle_count,
               pending_regions.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    upload_req_t     rq;
    region_item_t    owed;
    longint unsigned chain_total;
    int              n;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part: typed expectations where obvious, predictor elsewhere
    for (int i = 0; i < DIR_ROWS; i++) begin
      rq = DIRECTED[i].req;
      send_request(rq);
      owed = '0;
      case (DIRECTED[i].kind)
        ROW_ERROR: begin
          owed.no_usable_level = 1'b1;
          owe_item(owed);
        end
        ROW_SINGLE: begin
          owed.region.level_width  = rq.width;
          owed.region.level_height = rq.height;
          owed.region.level_bytes  = rq.data_size;
          owed.last_region         = 1'b1;
          owe_item(owed);
        end
        default: queue_prediction(rq);
      endcase
    end

    // random part: mostly blobs sized to hold the whole chain, the rest cut
    // short somewhere inside it, or arbitrary
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      rq.width  = rand_extent();
      rq.height = rand_extent();
      rq.fmt    = ($urandom_range(0, 9) == 0) ?
                  FMT_W'($urandom_range(FMT_UNKNOWN, FMT_UNKNOWN_TOP)) :
                  FMT_W'($urandom_range(FMT_BC1, FMT_R8));
      rq.levels = ($urandom_range(0, 4) == 0) ? REQ_W'($urandom) :
                  REQ_W'($urandom_range(0, 16));
      // size of the complete chain, found with an unbounded blob
      rq.data_size = '1;
      n = predict_regions(rq);
      chain_total = 0;
      for (int k = 0; k < n; k++) chain_total += chain_plan[k].region.level_bytes;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          chain_total += $urandom_range(0, 64);
          rq.data_size = (chain_total > 32'hFFFF_FFFF) ? '1 : chain_total[31:0];
        end
        6, 7:
          rq.data_size = (chain_total > 1) ? $urandom_range(0, 32'(chain_total - 1)) :
                         $urandom_range(0, 3);
        8:       rq.data_size = $urandom;
        default: rq.data_size = ($urandom_range(0, 1) == 0) ? '0 : '1;
      endcase
      send_request(rq);
      queue_prediction(rq);
    end
    s_tvalid <= 1'b0;

    // let the last chain drain, then watch a little longer for stray items
    while (pending_regions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d upload requests (%0d directed) in %0d cycles", request_count,
             DIR_ROWS, cycle_count);
    $display("checked %0d regions and %0d no-usable-level items, %0d mismatches",
             region_count, no_level_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== mip_chain_upload_region_generator_top.f =====
sv/mipc_pkg.sv
sv/mipc_cell.sv
sv/mipc_collect.sv
sv/mip_chain_upload_region_generator_top.sv
test/mip_chain_upload_region_generator_top_tb.sv
